// ===== rtl/disk_request_scheduler_sstf_assert.svh =====
// ----------------------------------------------------------------------------
// disk request scheduler assertion macros
// shared property templates for the scheduler's concurrent checks
// ----------------------------------------------------------------------------
`ifndef DISK_REQUEST_SCHEDULER_SSTF_ASSERT_SVH
`define DISK_REQUEST_SCHEDULER_SSTF_ASSERT_SVH

// same-cycle implication
`define DSS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DSS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg
// sizes, codes and control bundles shared by the scheduler modules
// ----------------------------------------------------------------------------
package dss_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int CYL_W       = 14;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STATUS_W    = 2;
	localparam int PCOUNT_W    = 7;
	localparam int S_TDATA_W   = ((CYL_W + 7) / 8) * 8;
	localparam int M_TDATA_W   = ((2 * CYL_W + PCOUNT_W + 7) / 8) * 8;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_SERVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED  = 2'd0,
		ST_SERVED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic do_add;
		logic do_full;
		logic do_empty;
		logic scan_start;
		logic shift_start;
		logic serve_done;
		logic res_send;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic scan_done;
		logic shift_done;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/disk_request_scheduler_sstf.sv =====
// ----------------------------------------------------------------------------
// disk_request_scheduler_sstf
// pending table of cylinder requests served oldest-first or nearest-first
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// s_*       in   s_tvalid / s_tready  tuser: func; tdata: cylinder
// m_*       out  m_tvalid / m_tready  tuser: status; tdata: served, seek, count
// cfg_*     in   cfg_we               cfg_wdata: policy_mode
//
// add, full add or empty serve: ready again once the result register is free
// serve: nearest-first mode scans all n pending requests, oldest-first mode
//   reads only the head entry; then the entries after the pick move down; the single read
//   port of the request memory sets this (one scan read, then one move a cycle)
// reset clears count, head and policy (nearest-first); no memory clearing pass
// a result waiting on m_tready holds the next result back but not acceptance
//
module disk_request_scheduler_sstf (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dss_pkg::S_TDATA_W-1:0]  s_tdata,   // [13:0] cylinder
	input  logic [0:0]                     s_tuser,   // [0] func
	// result channel
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [13:0] served_cylinder, [27:14] seek_distance, [34:28] pending_count
	output logic [dss_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [dss_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
	// policy register
	input  logic                           cfg_we,
	input  logic                           cfg_wdata
);

`include "disk_request_scheduler_sstf_assert.svh"

	dss_pkg::cmd_t  cmd;
	dss_pkg::stat_t stat;

	// sequencer: decides what each transaction does
	dss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (s_tuser[0]),
		.stat     (stat),
		.cmd      (cmd),
		.ready    (s_tready)
	);

	// memory, scan, compaction and output register
	dss_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.add_cyl   (s_tdata[dss_pkg::CYL_W-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// at most one result-producing action per cycle
	`DSS_ASSERT_IMP(a_one_action, clk, arst_n, 1'b1,
		($onehot0({cmd.do_add, cmd.do_full, cmd.do_empty, cmd.serve_done, cmd.res_send})),
		"more than one result action in a cycle")

	// an accepted transaction moves the sequencer out of idle, which drops s_tready
	`DSS_ASSERT_NXT(a_busy_after_accept, clk, arst_n, (s_tvalid && s_tready), (!s_tready),
		"request accepted twice in a row")

	// only a successful serve carries a cylinder and a seek distance
	`DSS_ASSERT_IMP(a_zero_unless_served, clk, arst_n,
		(m_tvalid && (m_tuser != dss_pkg::ST_SERVED)),
		(m_tdata[2*dss_pkg::CYL_W-1:0] == '0),
		"nonzero cylinder or seek on a result that is not a serve")

endmodule

// ===== rtl/dss_ram.sv =====
// ----------------------------------------------------------------------------
// dss_ram
// generic one-write one-read memory with registered read data
// ----------------------------------------------------------------------------
module dss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/dss_ctrl.sv =====
// ----------------------------------------------------------------------------
// dss_ctrl
// sequencer for add and serve transactions of the scheduler
// ----------------------------------------------------------------------------
module dss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  logic           func,
	input  dss_pkg::stat_t stat,
	output dss_pkg::cmd_t  cmd,
	output logic           ready
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_SHIFT = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				ready = 1'b1;
				if (s_tvalid) begin
					if (func == dss_pkg::FUNC_ADD) begin
						if (stat.full) begin
							cmd.do_full = 1'b1;
						end else begin
							cmd.do_add = 1'b1;
						end
						state_nxt = S_DONE;
					end else if (stat.empty) begin
						cmd.do_empty = 1'b1;
						state_nxt    = S_DONE;
					end else begin
						cmd.scan_start = 1'b1;
						state_nxt      = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					cmd.shift_start = 1'b1;
					state_nxt       = S_SHIFT;
				end
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					cmd.serve_done = 1'b1;
					state_nxt      = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.res_send = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/dss_datapath.sv =====
// ----------------------------------------------------------------------------
// dss_datapath
// request memory, nearest-cylinder scan, compaction and result registers
// ----------------------------------------------------------------------------
module dss_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dss_pkg::cmd_t                  cmd,
	output dss_pkg::stat_t                 stat,
	input  logic [dss_pkg::CYL_W-1:0]      add_cyl,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [dss_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic [dss_pkg::STATUS_W-1:0]   m_tuser
);

	localparam int CYL_W    = dss_pkg::CYL_W;
	localparam int IDX_W    = dss_pkg::IDX_W;
	localparam int CNT_W    = dss_pkg::CNT_W;
	localparam int PCOUNT_W = dss_pkg::PCOUNT_W;

	logic [CNT_W-1:0] count_q;
	logic [CYL_W-1:0] head_q;
	logic             policy_q;

	// scan pass
	logic             scan_busy_q;
	logic [CNT_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] scan_lim_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [IDX_W-1:0] best_idx_q;
	logic [CYL_W-1:0] best_dist_q;
	logic [CYL_W-1:0] best_cyl_q;

	// compaction pass
	logic             sh_busy_q;
	logic [CNT_W-1:0] sh_ptr_q;
	logic             wr_vld_s1;
	logic [IDX_W-1:0] wr_idx_s1;

	// pending result and output register
	dss_pkg::status_t  res_status_q;
	logic [CYL_W-1:0]  res_cyl_q;
	logic [CYL_W-1:0]  res_seek_q;
	logic              m_valid_q;
	dss_pkg::status_t  m_status_q;
	logic [CYL_W-1:0]  m_cyl_q;
	logic [CYL_W-1:0]  m_seek_q;
	logic [PCOUNT_W-1:0] m_count_q;

	logic             scan_issue;
	logic             sh_issue;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [CYL_W-1:0] ram_wdata;
	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [CYL_W-1:0] ram_rdata;
	logic [CYL_W-1:0] seek_d;
	logic             take_best;

	assign scan_issue = scan_busy_q && (rd_ptr_q < scan_lim_q);
	assign sh_issue   = sh_busy_q && (sh_ptr_q < count_q);

	assign ram_re    = scan_issue || sh_issue;
	assign ram_raddr = scan_busy_q ? rd_ptr_q[IDX_W-1:0] : sh_ptr_q[IDX_W-1:0];
	assign ram_we    = cmd.do_add || wr_vld_s1;
	assign ram_waddr = wr_vld_s1 ? wr_idx_s1 : count_q[IDX_W-1:0];
	assign ram_wdata = wr_vld_s1 ? ram_rdata : add_cyl;

	assign seek_d = (ram_rdata >= head_q) ? (ram_rdata - head_q) : (head_q - ram_rdata);
	// strict less keeps the earliest of tied entries
	assign take_best = rd_vld_s1 && ((rd_idx_s1 == '0) || (seek_d < best_dist_q));

	assign stat.full       = (count_q == CNT_W'(dss_pkg::QUEUE_DEPTH));
	assign stat.empty      = (count_q == '0);
	assign stat.scan_done  = scan_busy_q && !scan_issue && !rd_vld_s1;
	assign stat.shift_done = sh_busy_q && !sh_issue && !wr_vld_s1;
	assign stat.out_free   = !m_valid_q || m_tready;

	dss_ram #(
		.WIDTH (CYL_W),
		.DEPTH (dss_pkg::QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_q      <= '0;
			policy_q    <= 1'b1;
			scan_busy_q <= 1'b0;
			rd_ptr_q    <= '0;
			scan_lim_q  <= '0;
			rd_vld_s1   <= 1'b0;
			sh_busy_q   <= 1'b0;
			sh_ptr_q    <= '0;
			wr_vld_s1   <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			rd_vld_s1 <= scan_issue;
			wr_vld_s1 <= sh_issue;
			if (cmd.do_add) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.scan_start) begin
				scan_busy_q <= 1'b1;
				rd_ptr_q    <= '0;
				// oldest-first mode looks only at the head of the table
				scan_lim_q  <= policy_q ? count_q : CNT_W'(1);
			end else if (scan_issue) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
			if (cmd.shift_start) begin
				scan_busy_q <= 1'b0;
				sh_busy_q   <= 1'b1;
				sh_ptr_q    <= CNT_W'(best_idx_q) + CNT_W'(1);
			end else if (sh_issue) begin
				sh_ptr_q <= sh_ptr_q + CNT_W'(1);
			end
			if (cmd.serve_done) begin
				sh_busy_q <= 1'b0;
				count_q   <= count_q - CNT_W'(1);
				head_q    <= best_cyl_q;
			end
			if (cmd.res_send) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_ptr_q[IDX_W-1:0];
		wr_idx_s1 <= IDX_W'(sh_ptr_q - CNT_W'(1));
		if (take_best) begin
			best_idx_q  <= rd_idx_s1;
			best_dist_q <= seek_d;
			best_cyl_q  <= ram_rdata;
		end
		if (cmd.do_add) begin
			res_status_q <= dss_pkg::ST_ADDED;
			res_cyl_q    <= '0;
			res_seek_q   <= '0;
		end else if (cmd.do_full) begin
			res_status_q <= dss_pkg::ST_FULL;
			res_cyl_q    <= '0;
			res_seek_q   <= '0;
		end else if (cmd.do_empty) begin
			res_status_q <= dss_pkg::ST_EMPTY;
			res_cyl_q    <= '0;
			res_seek_q   <= '0;
		end else if (cmd.serve_done) begin
			res_status_q <= dss_pkg::ST_SERVED;
			res_cyl_q    <= best_cyl_q;
			res_seek_q   <= best_dist_q;
		end
		if (cmd.res_send) begin
			m_status_q <= res_status_q;
			m_cyl_q    <= res_cyl_q;
			m_seek_q   <= res_seek_q;
			m_count_q  <= PCOUNT_W'(count_q);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = dss_pkg::M_TDATA_W'({m_count_q, m_seek_q, m_cyl_q});

endmodule

// ===== tb/sv/disk_request_scheduler_sstf_tb.sv =====
// ----------------------------------------------------------------------------
// disk_request_scheduler_sstf_tb
// self-checking bench: adds and serves go in on the request stream, every
// result is checked against a behavioral scheduler model, and the policy
// register is switched between phases
// ----------------------------------------------------------------------------
module disk_request_scheduler_sstf_tb;

	import dss_pkg::*;

	// policy register values
	localparam logic POLICY_FIFO = 1'b0;
	localparam logic POLICY_SSTF = 1'b1;

	// run sizing
	localparam int RANDOM_ITEMS = 700;
	localparam int CALM_ITEMS   = 150;   // tail of the run with no idling
	localparam int PHASE_ITEMS  = 90;
	localparam int STALL_LIMIT  = 4000;  // watchdog bound, above a full-table serve plus stalls
	localparam int DRAIN_CYCLES = 200;

	// result tdata layout
	localparam int SERVED_LSB = 0;
	localparam int SEEK_LSB   = CYL_W;
	localparam int COUNT_LSB  = 2 * CYL_W;

	typedef enum int {
		BURST_FILL,
		BURST_DRAIN,
		BURST_MIX,
		BURST_CLUSTER
	} burst_kind_t;

	typedef struct {
		logic             func;
		logic [CYL_W-1:0] cyl;
	} request_t;

	typedef struct {
		status_t             status;
		logic [CYL_W-1:0]    served;
		logic [CYL_W-1:0]    seek;
		logic [PCOUNT_W-1:0] count;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;
	logic                 cfg_we;
	logic                 cfg_wdata;

	// requests not yet accepted by the block, front one is on the bus
	request_t request_feed[$];
	// results predicted at acceptance, oldest first
	outcome_t awaited_outcomes[$];

	// scheduler model state: pending cylinders in arrival order, head, policy
	logic [CYL_W-1:0] tbl_cyl[$];
	logic [CYL_W-1:0] tbl_head;
	logic             tbl_policy;

	int   fail_count;
	int   quiet_cycles;
	logic in_xact;       // request transaction at the last rising edge
	int   in_gap;
	int   out_gap;
	int   in_idle_pct;
	int   out_idle_pct;

	disk_request_scheduler_sstf dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// scheduler model
	// ------------------------------------------------------------------------

	function automatic logic [CYL_W-1:0] cyl_gap(input logic [CYL_W-1:0] a,
		input logic [CYL_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// applies one request to the model and returns the result it must produce
	function automatic outcome_t schedule_outcome(input logic func,
		input logic [CYL_W-1:0] cyl);
		outcome_t         res;
		int               pick;
		logic [CYL_W-1:0] best_d;
		logic [CYL_W-1:0] d;
		res.status = ST_ADDED;
		res.served = '0;
		res.seek   = '0;
		if (func == FUNC_ADD) begin
			// full table drops the add, nothing else changes
			if (tbl_cyl.size() >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				tbl_cyl.push_back(cyl);
			end
		end else if (tbl_cyl.size() == 0) begin
			// empty serve leaves the head where it is
			res.status = ST_EMPTY;
		end else begin
			pick = 0;
			if (tbl_policy == POLICY_SSTF) begin
				// strict less-than keeps the earliest of tied requests
				best_d = cyl_gap(tbl_cyl[0], tbl_head);
				for (int i = 1; i < tbl_cyl.size(); i++) begin
					d = cyl_gap(tbl_cyl[i], tbl_head);
					if (d < best_d) begin
						best_d = d;
						pick   = i;
					end
				end
			end
			res.status = ST_SERVED;
			res.served = tbl_cyl[pick];
			res.seek   = cyl_gap(tbl_cyl[pick], tbl_head);
			tbl_cyl.delete(pick);    // later entries close the gap
			tbl_head = res.served;
		end
		res.count = PCOUNT_W'(tbl_cyl.size());
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// monitor: predicts on request transactions, checks result transactions,
	// tracks policy writes and watches for a hung block
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n) begin
			in_xact <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				awaited_outcomes.push_back(schedule_outcome(s_tuser[0],
					s_tdata[CYL_W-1:0]));
			end
			if (cfg_we) begin
				tbl_policy = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.served = m_tdata[SERVED_LSB +: CYL_W];
				got.seek   = m_tdata[SEEK_LSB +: CYL_W];
				got.count  = m_tdata[COUNT_LSB +: PCOUNT_W];
				if (awaited_outcomes.size() == 0) begin
					$error("result transaction with no request outstanding");
					fail_count++;
				end else begin
					want = awaited_outcomes.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.served != want.served) begin
						$error("served_cylinder: expected %0d, actual %0d",
							want.served, got.served);
						fail_count++;
					end
					if (got.seek != want.seek) begin
						$error("seek_distance: expected %0d, actual %0d", want.seek, got.seek);
						fail_count++;
					end
					if (got.count != want.count) begin
						$error("pending_count: expected %0d, actual %0d", want.count, got.count);
						fail_count++;
					end
				end
			end
			// watchdog: any transaction or register write counts as progress
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// request driver: holds the front item until its transaction, with
	// random idle bursts between items
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_xact) begin
				request_feed.delete(0);
			end
			if (!s_tvalid || in_xact) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (request_feed.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if ($urandom_range(1, 100) <= in_idle_pct) begin
					in_gap = $urandom_range(0, 2);
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tuser  <= request_feed[0].func;
					s_tdata  <= S_TDATA_W'(request_feed[0].cyl);
				end
			end
		end
	end

	// result side back-pressure, same burst shape
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(1, 100) <= out_idle_pct) begin
				out_gap = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequencing
	// ------------------------------------------------------------------------

	task automatic queue_request(input logic func, input logic [CYL_W-1:0] cyl);
		request_feed.push_back('{func: func, cyl: cyl});
	endtask

	// block idle: all items accepted, all results back, ready again
	task automatic settle();
		do @(negedge clk);
		while (request_feed.size() != 0 || awaited_outcomes.size() != 0 || !s_tready);
	endtask

	task automatic set_policy(input logic mode);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// one run of requests: fill drives the table to full and beyond, drain
	// empties it and keeps serving, mix balances adds and serves, cluster packs
	// cylinders close together for ties and zero-length seeks
	task automatic queue_burst(output int n);
		burst_kind_t      kind;
		int               add_pct;
		int               base;
		logic             func;
		logic [CYL_W-1:0] cyl;
		kind = burst_kind_t'($urandom_range(0, 3));
		base = $urandom_range(0, (1 << CYL_W) - 16);
		case (kind)
			BURST_FILL: begin
				n = $urandom_range(60, 72);
				add_pct = 95;
			end
			BURST_DRAIN: begin
				n = $urandom_range(60, 72);
				add_pct = 5;
			end
			BURST_MIX: begin
				n = $urandom_range(20, 40);
				add_pct = 50;
			end
			default: begin
				n = $urandom_range(20, 40);
				add_pct = 60;
			end
		endcase
		for (int i = 0; i < n; i++) begin
			func = ($urandom_range(1, 100) <= add_pct) ? FUNC_ADD : FUNC_SERVE;
			if (kind == BURST_CLUSTER) begin
				cyl = CYL_W'(base + $urandom_range(0, 15));
			end else begin
				case ($urandom_range(0, 5))
					0:       cyl = $urandom_range(0, 1) ? '1 : '0;
					1:       cyl = CYL_W'($urandom_range(0, 15));
					2:       cyl = CYL_W'((1 << CYL_W) - 1 - $urandom_range(0, 15));
					default: cyl = CYL_W'($urandom);
				endcase
			end
			queue_request(func, cyl);
		end
	endtask

	initial begin
		int made;
		int phase_made;
		int burst_n;
		int phase_no;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		tbl_head     = '0;
		tbl_policy   = POLICY_SSTF;  // register reset value
		fail_count   = 0;
		quiet_cycles = 0;
		in_xact      = 1'b0;
		in_gap       = 0;
		out_gap      = 0;
		in_idle_pct  = 20;
		out_idle_pct = 20;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nearest-first from reset: empty serve, seek of zero, extremes and a tie
		queue_request(FUNC_SERVE, '1);
		queue_request(FUNC_ADD, '0);
		queue_request(FUNC_SERVE, '0);     // head already at 0
		queue_request(FUNC_ADD, '1);
		queue_request(FUNC_ADD, 50);
		queue_request(FUNC_ADD, 60);
		queue_request(FUNC_ADD, 40);
		queue_request(FUNC_SERVE, '0);     // nearest is 40
		queue_request(FUNC_ADD, 30);
		queue_request(FUNC_SERVE, '0);     // 50 and 30 both 10 away, 50 is older
		queue_request(FUNC_SERVE, '0);
		queue_request(FUNC_SERVE, '0);
		queue_request(FUNC_SERVE, '0);     // longest seek, out to the top cylinder
		queue_request(FUNC_SERVE, '0);
		settle();

		// oldest-first in arrival order regardless of distance
		set_policy(POLICY_FIFO);
		queue_request(FUNC_ADD, 5);
		queue_request(FUNC_ADD, '1);
		queue_request(FUNC_ADD, '0);
		queue_request(FUNC_SERVE, '1);
		queue_request(FUNC_SERVE, '0);
		queue_request(FUNC_SERVE, '0);
		queue_request(FUNC_SERVE, '0);
		settle();

		// random phases, policy rewritten between each, table carried over
		made     = 0;
		phase_no = 0;
		while (made < RANDOM_ITEMS) begin
			set_policy(phase_no < 2 ? phase_no[0] : 1'($urandom_range(0, 1)));
			if (made >= RANDOM_ITEMS - CALM_ITEMS) begin
				in_idle_pct  = 0;
				out_idle_pct = 0;
			end else begin
				in_idle_pct  = 20 * $urandom_range(0, 2);
				out_idle_pct = 20 * $urandom_range(0, 2);
			end
			phase_made = 0;
			while (phase_made < PHASE_ITEMS) begin
				queue_burst(burst_n);
				phase_made += burst_n;
			end
			made += phase_made;
			phase_no++;
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
